[src/rrq_pkg.sv]
// rrq_pkg: shared constants, codes and beat types for the report ring queue
// used by rrq_front, rrq_back and report_ring_queue_drop_oldest
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

	// ring geometry
	localparam int REPORT_BYTES = 64;
	localparam int SLOT_COUNT   = 8;

	// command queue between front and back, power of two
	localparam int QUEUE_DEPTH  = 4;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int BYTE_W = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
	localparam int ADDR_W = $clog2(SLOT_COUNT * REPORT_BYTES);
	localparam int LEN_W  = 7;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// command codes on the request channel
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// classified operation held in the command queue
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} rrq_op_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [LEN_W-1:0] capacity;
	} rrq_req_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             is_last;
		logic [LEN_W-1:0] read_length;
		logic             nothing_read;
	} rrq_rsp_t;

	typedef struct packed {
		rrq_op_t          op;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [LEN_W-1:0] capacity;
	} rrq_entry_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic       valid;
		rrq_entry_t entry;
	} rrq_qhead_t;

endpackage

`default_nettype wire

[src/report_ring_queue_drop_oldest.sv]
// report_ring_queue_drop_oldest: ring of report slots, drops the oldest report when full
// instantiates rrq_front and rrq_back; depends on rrq_pkg
//
// Request channel (req_valid, req_stall, req) carries one command per beat: write one
// report byte (last_byte commits the report), read the oldest report up to a byte
// capacity, or clear the ring. Response channel (rsp_valid, rsp_stall, rsp) carries
// one beat per report byte read; an empty ring or zero capacity gives a single beat
// with nothing_read set. Writes and clears give no beat.
// Commands pass through a four-entry queue to the executing back end, which takes one
// write or clear per cycle while no read holds it and streams read bytes at one per
// cycle while the output buffer has room; a read holds the back end until its last beat
// is issued. The first beat of a read passes through the command queue, the registered
// slot memory read and the two-entry output buffer.
// req_stall rises only when the command queue is full. When the receiver stalls, the
// two-entry output buffer fills, the read stream pauses, then the queue fills and
// requests stall in turn; no beat is lost.
// Reset empties the ring and the queue; slot storage is not cleared and needs no
// clearing pass, so requests are taken from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module report_ring_queue_drop_oldest import rrq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire rrq_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output rrq_rsp_t      rsp
);

	rrq_qhead_t qhead;
	logic       pop;

	// accept and classify commands
	rrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qhead     (qhead),
		.pop       (pop)
	);

	// execute commands on the ring
	rrq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qhead     (qhead),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[src/rrq_front.sv]
// rrq_front: accepts request beats, classifies the command and queues it
// depends on rrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrq_front import rrq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire rrq_req_t   req,
	output rrq_qhead_t      qhead,
	input  wire logic       pop
);

	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	rrq_entry_t        fifo_q [QUEUE_DEPTH];

	logic       accept;
	logic       keep;
	logic       push;
	rrq_entry_t entry;

	// classify the command, the unused code is dropped here
	always_comb begin
		keep            = 1'b1;
		entry.op        = OP_WRITE;
		entry.data_byte = req.data_byte;
		entry.last_byte = req.last_byte;
		entry.capacity  = req.capacity;
		unique case (req.cmd)
			CMD_WRITE: entry.op = OP_WRITE;
			CMD_READ:  entry.op = OP_READ;
			CMD_CLEAR: entry.op = OP_CLEAR;
			default:   keep = 1'b0;
		endcase
	end

	assign req_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept    = req_valid && !req_stall;
	assign push      = accept && keep;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign qhead.valid = (cnt_q != '0);
	assign qhead.entry = fifo_q[rd_ptr_q];

	// checks
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("command queue popped while empty");

	a_unused_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == CMD_NONE) && !pop) |=> $stable(cnt_q))
		else $error("unused command code entered the queue");

	a_read_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == CMD_READ) && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
		else $error("read command lost at the queue");

endmodule

`default_nettype wire

[src/rrq_back.sv]
// rrq_back: executes queued commands on the report ring and streams read beats
// holds the slot memory, ring pointers and a two-entry output buffer; depends on rrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrq_back import rrq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rrq_qhead_t qhead,
	output logic            pop,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rrq_rsp_t        rsp
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} rrq_state_t;

	function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
		if (i == SLOT_W'(SLOT_COUNT - 1)) begin
			return '0;
		end
		return i + SLOT_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
			input logic [BYTE_W-1:0] idx);
		return ADDR_W'(ADDR_W'(slot) * ADDR_W'(REPORT_BYTES) + ADDR_W'(idx));
	endfunction

	// ring state
	rrq_state_t        state_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [LEN_W-1:0]  fill_q;
	logic [BYTE_W-1:0] idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  slot_len_q [SLOT_COUNT];
	logic [7:0]        slot_mem_q [SLOT_COUNT * REPORT_BYTES];

	// read pipe and output buffer
	logic       rd_valid_s1;
	rrq_rsp_t   rd_meta_s1;
	logic [7:0] rd_byte_s1;
	rrq_rsp_t   buf_q [2];
	logic       buf_wr_q;
	logic       buf_rd_q;
	logic [1:0] occ_q;

	// next-state and control
	rrq_state_t        state_d;
	logic [SLOT_W-1:0] head_d;
	logic [SLOT_W-1:0] tail_d;
	logic [LEN_W-1:0]  fill_d;
	logic [BYTE_W-1:0] idx_d;
	logic [LEN_W-1:0]  len_d;
	logic              mem_we;
	logic              slen_we;
	logic [LEN_W-1:0]  fill_new;
	logic              issue;
	logic [BYTE_W-1:0] issue_idx;
	rrq_rsp_t          issue_meta;
	logic              rsp_pop;
	logic [1:0]        used;
	logic              credit;
	logic [LEN_W-1:0]  avail_len;
	logic [LEN_W-1:0]  read_len;
	logic              stream_last;
	rrq_entry_t        entry;
	rrq_rsp_t          push_item;

	assign entry   = qhead.entry;
	assign rsp_pop = rsp_valid && !rsp_stall;

	// a beat may be issued when it is sure to find room in the output buffer
	assign used   = occ_q + {1'b0, rd_valid_s1};
	assign credit = (used < 2'd2) || rsp_pop;

	// bytes a read delivers: stored length clipped to the capacity
	assign avail_len = slot_len_q[tail_q];
	always_comb begin
		if ((head_q == tail_q) || (entry.capacity == '0)) begin
			read_len = '0;
		end else if (avail_len < entry.capacity) begin
			read_len = avail_len;
		end else begin
			read_len = entry.capacity;
		end
	end

	assign fill_new    = (fill_q < LEN_W'(REPORT_BYTES)) ? fill_q + LEN_W'(1) : fill_q;
	assign stream_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	// command sequencer
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		idx_d      = idx_q;
		len_d      = len_q;
		pop        = 1'b0;
		mem_we     = 1'b0;
		slen_we    = 1'b0;
		issue      = 1'b0;
		issue_idx  = '0;
		issue_meta = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (qhead.valid) begin
					unique case (entry.op)
						OP_WRITE: begin
							pop    = 1'b1;
							mem_we = (fill_q < LEN_W'(REPORT_BYTES));
							if (entry.last_byte) begin
								slen_we = 1'b1;
								head_d  = ring_next(head_q);
								fill_d  = '0;
								// ring full: the oldest report goes
								if (ring_next(head_q) == tail_q) begin
									tail_d = ring_next(tail_q);
								end
							end else begin
								fill_d = fill_new;
							end
						end
						OP_READ: begin
							if (credit) begin
								pop   = 1'b1;
								issue = 1'b1;
								if (read_len == '0) begin
									issue_meta.is_last      = 1'b1;
									issue_meta.nothing_read = 1'b1;
								end else begin
									issue_meta.read_length = read_len;
									issue_meta.is_last     = (read_len == LEN_W'(1));
									if (read_len == LEN_W'(1)) begin
										tail_d = ring_next(tail_q);
									end else begin
										state_d = ST_STREAM;
										idx_d   = BYTE_W'(1);
										len_d   = read_len;
									end
								end
							end
						end
						OP_CLEAR: begin
							pop    = 1'b1;
							head_d = '0;
							tail_d = '0;
							fill_d = '0;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_STREAM: begin
				if (credit) begin
					issue                  = 1'b1;
					issue_idx              = idx_q;
					issue_meta.read_length = len_q;
					issue_meta.is_last     = stream_last;
					if (stream_last) begin
						tail_d  = ring_next(tail_q);
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + BYTE_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			fill_q      <= fill_d;
			idx_q       <= idx_d;
			len_q       <= len_d;
			rd_valid_s1 <= issue;
		end
	end

	// slot memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[slot_addr(head_q, fill_q[BYTE_W-1:0])] <= entry.data_byte;
		end
		if (issue) begin
			rd_byte_s1 <= slot_mem_q[slot_addr(tail_q, issue_idx)];
			rd_meta_s1 <= issue_meta;
		end
	end

	// stored report lengths
	always_ff @(posedge clk) begin
		if (slen_we) begin
			slot_len_q[head_q] <= fill_new;
		end
	end

	// output buffer, two beats deep
	always_comb begin
		push_item          = rd_meta_s1;
		push_item.out_byte = rd_meta_s1.nothing_read ? 8'd0 : rd_byte_s1;
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			buf_q[buf_wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_wr_q <= 1'b0;
			buf_rd_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (rd_valid_s1) begin
				buf_wr_q <= !buf_wr_q;
			end
			if (rsp_pop) begin
				buf_rd_q <= !buf_rd_q;
			end
			case ({rd_valid_s1, rsp_pop})
				2'b10:   occ_q <= occ_q + 2'd1;
				2'b01:   occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign rsp_valid = (occ_q != '0);
	assign rsp       = buf_q[buf_rd_q];

	// checks
	a_buffer_room: assert property (@(posedge clk) disable iff (!arst_n)
		!((occ_q == 2'd2) && rd_valid_s1))
		else $error("read beat arrived at a full output buffer");

	a_stream_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> (head_q != tail_q))
		else $error("streaming from an empty ring");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(REPORT_BYTES))
		else $error("fill count beyond slot size");

	a_stream_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STREAM) && issue && stream_last) |=> (state_q == ST_IDLE))
		else $error("stream did not end on its last beat");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for report_ring_queue_drop_oldest, directed table then random
// commands, checked beat by beat against an in-bench model of the report ring
// depends on rrq_pkg and report_ring_queue_drop_oldest
`timescale 1ns / 1ps

module tb_top;
	import rrq_pkg::*;

	localparam int RANDOM_ITEMS    = 280;
	localparam int SQUEEZE_AT      = 150;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int DRAIN_TAIL      = 20;

	// one line of the directed script; a row repeats reps times with data counting up
	typedef struct packed {
		logic [1:0]       cmd;
		logic [7:0]       data;
		logic             last;
		logic [LEN_W-1:0] cap;
		logic [7:0]       reps;
		logic             every;
		logic             typed;
		rrq_rsp_t         want;
	} script_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	rrq_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	rrq_rsp_t rsp;

	// model of the ring
	logic [7:0] ring_bytes [SLOT_COUNT][REPORT_BYTES];
	int         ring_lens [SLOT_COUNT];
	int         ring_head = 0;
	int         ring_tail = 0;
	int         fill_cnt  = 0;

	rrq_rsp_t    beats_due[$];
	script_row_t script[$];
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	bit          sender_calm  = 1'b0;
	bit          squeeze_go   = 1'b0;

	report_ring_queue_drop_oldest u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic rrq_rsp_t make_beat(input logic [7:0] b, input logic lst,
			input logic [LEN_W-1:0] len, input logic none);
		rrq_rsp_t t;
		t.out_byte     = b;
		t.is_last      = lst;
		t.read_length  = len;
		t.nothing_read = none;
		return t;
	endfunction

	// advance the ring by one command; read beats are queued when keep is set
	function automatic void predict_ring(input rrq_req_t r, input bit keep);
		int nxt;
		int n;
		case (r.cmd)
			CMD_WRITE: begin
				if (fill_cnt < REPORT_BYTES) begin
					ring_bytes[ring_head][fill_cnt] = r.data_byte;
					fill_cnt++;
				end
				if (r.last_byte) begin
					nxt = (ring_head + 1) % SLOT_COUNT;
					// full ring: oldest report goes
					if (nxt == ring_tail)
						ring_tail = (ring_tail + 1) % SLOT_COUNT;
					ring_lens[ring_head] = fill_cnt;
					ring_head = nxt;
					fill_cnt  = 0;
				end
			end
			CMD_READ: begin
				n = 0;
				if (ring_head != ring_tail && r.capacity != 0) begin
					n = ring_lens[ring_tail];
					if (n > r.capacity)
						n = r.capacity;
				end
				if (n == 0) begin
					if (keep)
						beats_due.push_back(make_beat(8'h00, 1'b1, '0, 1'b1));
				end else begin
					for (int k = 0; k < n; k++) begin
						if (keep)
							beats_due.push_back(make_beat(ring_bytes[ring_tail][k],
								k == n - 1, LEN_W'(n), 1'b0));
					end
					ring_tail = (ring_tail + 1) % SLOT_COUNT;
				end
			end
			CMD_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				fill_cnt  = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(input logic [1:0] cmd, input logic [7:0] data,
			input logic last, input logic [LEN_W-1:0] cap, input logic [7:0] reps,
			input logic every, input logic typed, input rrq_rsp_t want);
		script_row_t row;
		row.cmd   = cmd;
		row.data  = data;
		row.last  = last;
		row.cap   = cap;
		row.reps  = reps;
		row.every = every;
		row.typed = typed;
		row.want  = want;
		script.push_back(row);
	endfunction

	// offer one command beat and wait for it to be taken
	task automatic offer_cmd(input rrq_req_t r, input bit typed, input rrq_rsp_t want);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_ring(r, !typed);
		if (typed)
			beats_due.push_back(want);
	endtask

	function automatic rrq_req_t make_cmd(input logic [1:0] cmd, input logic [7:0] data,
			input logic last, input logic [LEN_W-1:0] cap);
		rrq_req_t r;
		r.cmd       = cmd;
		r.data_byte = data;
		r.last_byte = last;
		r.capacity  = cap;
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] pick_capacity();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel < 4)
			return LEN_W'($urandom_range(1, 8));
		else if (sel < 6)
			return LEN_W'($urandom_range(1, REPORT_BYTES));
		return LEN_W'(REPORT_BYTES);
	endfunction

	// stimulus: directed script, then random reports, reads and clears
	initial begin : cmd_source
		rrq_rsp_t    none_beat;
		rrq_rsp_t    dummy;
		rrq_req_t    r;
		script_row_t row;
		int          sent;
		int          mood_at;
		int          pick;
		int          len;
		int          waited;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		none_beat = make_beat(8'h00, 1'b1, '0, 1'b1);
		dummy     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty after reset, zero capacity, ignored code, truncation, drop, clear
		add_row(CMD_READ,  8'h00, 1'b0, 7'd5,  8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_WRITE, 8'h00, 1'b0, 7'd0,  8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_WRITE, 8'hFF, 1'b1, 7'd0,  8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'hFF, 1'b1, 7'd0,  8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_WRITE, 8'hA5, 1'b1, 7'd0,  8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd1,  8'd1,  1'b0, 1'b1,
			make_beat(8'hA5, 1'b1, 7'd1, 1'b0));
		add_row(CMD_NONE,  8'hFF, 1'b1, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_WRITE, 8'h10, 1'b1, 7'd0,  8'd70, 1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_WRITE, 8'h80, 1'b1, 7'd0,  8'd64, 1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd10, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_WRITE, 8'h30, 1'b1, 7'd0,  8'd9,  1'b1, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_WRITE, 8'h55, 1'b0, 7'd0,  8'd5,  1'b0, 1'b0, dummy);
		add_row(CMD_CLEAR, 8'h00, 1'b0, 7'd0,  8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b1, none_beat);
		add_row(CMD_WRITE, 8'hE0, 1'b1, 7'd0,  8'd3,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd2,  8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_WRITE, 8'h01, 1'b1, 7'd0,  8'd7,  1'b1, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_CLEAR, 8'hFF, 1'b1, 7'd64, 8'd1,  1'b0, 1'b0, dummy);
		add_row(CMD_READ,  8'h00, 1'b0, 7'd64, 8'd1,  1'b0, 1'b1, none_beat);

		// walk the script
		foreach (script[i]) begin
			row = script[i];
			for (int k = 0; k < row.reps; k++) begin
				r = make_cmd(row.cmd, row.data + 8'(k),
					(row.every || k == row.reps - 1) ? row.last : 1'b0, row.cap);
				offer_cmd(r, row.typed, row.want);
			end
		end

		// random part, mostly whole reports and reads
		sent    = 0;
		mood_at = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= mood_at) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				mood_at     = sent + $urandom_range(10, 40);
			end
			if (sent >= SQUEEZE_AT)
				squeeze_go = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// whole report, now and then overlong
				pick = $urandom_range(0, 19);
				if (pick < 16)
					len = $urandom_range(1, 8);
				else if (pick < 19)
					len = $urandom_range(9, REPORT_BYTES);
				else
					len = $urandom_range(REPORT_BYTES + 1, REPORT_BYTES + 8);
				for (int k = 0; k < len; k++)
					offer_cmd(make_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), k == len - 1,
						LEN_W'($urandom_range(0, REPORT_BYTES))), 1'b0, dummy);
				sent += len;
			end else if (pick < 85) begin
				offer_cmd(make_cmd(CMD_READ, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_capacity()), 1'b0, dummy);
				sent++;
			end else if (pick < 92) begin
				// broken report, abandoned by a clear
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++)
					offer_cmd(make_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, '0),
						1'b0, dummy);
				offer_cmd(make_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_capacity()), 1'b0, dummy);
				sent += len + 1;
			end else if (pick < 95) begin
				offer_cmd(make_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_capacity()), 1'b0, dummy);
				sent++;
			end else begin
				offer_cmd(make_cmd(CMD_NONE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_capacity()), 1'b0, dummy);
			end
		end
		req_valid <= 1'b0;

		// drain outstanding read beats
		waited = 0;
		while (beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_TAIL) @(posedge clk);
		if (beats_due.size() != 0) begin
			$display("%0t: %0d expected read beats never arrived", $time, beats_due.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("report_ring_queue_drop_oldest regression: pass");
		end else begin
			$display("report_ring_queue_drop_oldest regression: fail");
		end
		$finish;
	end

	// read side: random stalls, calm stretches and one long hold-off
	initial begin : beat_sink
		int hold;
		int mood_left;
		bit rsp_calm;
		bit squeeze_done;
		rsp_stall <= 1'b0;
		rsp_calm     = 1'b0;
		squeeze_done = 1'b0;
		mood_left    = 30;
		forever begin
			@(posedge clk);
			if (squeeze_go && !squeeze_done) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				squeeze_done = 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				if (mood_left == 0) begin
					rsp_calm  = ($urandom_range(0, 3) == 0);
					mood_left = $urandom_range(20, 80);
				end else begin
					mood_left--;
				end
				hold = rsp_calm ? 0 : $urandom_range(0, 6);
				if (hold != 0) begin
					rsp_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// compare each taken read beat with the oldest expected one
	always @(posedge clk) begin : beat_check
		rrq_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (beats_due.size() == 0) begin
				$display("%0t: unexpected read beat, got byte %02h last %b len %0d none %b",
					$time, rsp.out_byte, rsp.is_last, rsp.read_length, rsp.nothing_read);
				mismatches++;
			end else begin
				want = beats_due.pop_front();
				if (rsp.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h",
						$time, want.out_byte, rsp.out_byte);
					mismatches++;
				end
				if (rsp.is_last !== want.is_last) begin
					$display("%0t: is_last expected %b got %b",
						$time, want.is_last, rsp.is_last);
					mismatches++;
				end
				if (rsp.read_length !== want.read_length) begin
					$display("%0t: read_length expected %0d got %0d",
						$time, want.read_length, rsp.read_length);
					mismatches++;
				end
				if (rsp.nothing_read !== want.nothing_read) begin
					$display("%0t: nothing_read expected %b got %b",
						$time, want.nothing_read, rsp.nothing_read);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no beat taken on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no beat taken for %0d cycles", $time, quiet_cycles);
			$display("report_ring_queue_drop_oldest regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
